[sv/mxdq_pkg.sv]
// Package: shared constants and element decode function for the MXFP4 dequantizer.
`timescale 1ns / 1ps
`default_nettype none
package mxdq_pkg;

    localparam int PAIRS_PER_BLOCK_DEF = 16;
    localparam logic [7:0] SCALE_ZERO_LO = 8'd0;
    localparam logic [7:0] SCALE_ZERO_HI = 8'd255;
    localparam logic [15:0] BF16_INF_MAG = 16'h7F80;
    localparam logic [15:0] BF16_MIN_HALF = 16'h0040;

    // Multiply one E2M1 code by the E8M0 scale exponent; exact bf16.
    function automatic logic [15:0] decode_elem(input logic [3:0] code, input logic [7:0] sexp);
        logic       sgn;
        logic [2:0] mag;
        logic [8:0] ebias;
        logic       mbit;
        logic [15:0] res;
        sgn = code[3];
        mag = code[2:0];
        res = {sgn, 15'd0};
        if (mag == 3'd0 || sexp == 8'd0)
        begin
            res = {sgn, 15'd0};
        end
        else if (mag == 3'd1 && sexp == 8'd1)
        begin
            res = {sgn, BF16_MIN_HALF[14:0]};
        end
        else
        begin
            if (mag == 3'd1)
            begin
                ebias = {1'b0, sexp} - 9'd1;
                mbit = 1'b0;
            end
            else
            begin
                ebias = {1'b0, sexp} + {7'd0, mag[2:1]} - 9'd1;
                mbit = mag[0];
            end
            if (ebias >= 9'd255)
                res = {sgn, BF16_INF_MAG[14:0]};
            else
                res = {sgn, ebias[7:0], mbit, 6'd0};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[sv/mxfp4_block_dequant_bf16_unit.sv]
// Top level: MXFP4 block dequantizer producing bf16 element pairs.
//
//  channel | direction | handshake           | payload
//  in      | into      | in_valid/in_stall   | data_byte
//  out     | out of    | out_valid/out_stall | value_even, value_odd, pair_index, block_last
//
// One byte is taken per cycle while in_stall is low; a pair byte yields its result in the next cycle
// from the output register, a scale byte yields none.
// Reset clears the byte position and scale; the first byte is a scale byte.
// in_stall follows out_stall only while the output register holds a result.
`timescale 1ns / 1ps
`default_nettype none
module mxfp4_block_dequant_bf16_unit #(
    parameter int PAIRS_PER_BLOCK = mxdq_pkg::PAIRS_PER_BLOCK_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      value_even,
    output logic [15:0]      value_odd,
    output logic [3:0]       pair_index,
    output logic             block_last
);
    import mxdq_pkg::*;

    logic       take;
    logic       is_pair;
    logic [3:0] pidx;
    logic       plast;
    logic [7:0] sexp;

    logic        ov_reg;
    logic [15:0] ev_reg, od_reg;
    logic [3:0]  pi_reg;
    logic        bl_reg;

    assign in_stall = ov_reg && out_stall;
    assign take = in_valid && !in_stall;

    mxdq_seq #(.PAIRS_PER_BLOCK(PAIRS_PER_BLOCK)) u_seq (
        .clk(clk), .rst_n(rst_n), .take(take), .data_byte(data_byte),
        .is_pair(is_pair), .pair_index(pidx), .block_last(plast), .scale_exp(sexp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (!in_stall)
            ov_reg <= take && is_pair;
    end

    // Load payload on every pair transfer.
    always_ff @(posedge clk)
    begin
        if (take && is_pair)
        begin
            ev_reg <= decode_elem(data_byte[3:0], sexp);
            od_reg <= decode_elem(data_byte[7:4], sexp);
            pi_reg <= pidx;
            bl_reg <= plast;
        end
    end

    assign out_valid  = ov_reg;
    assign value_even = ev_reg;
    assign value_odd  = od_reg;
    assign pair_index = pi_reg;
    assign block_last = bl_reg;
endmodule
`default_nettype wire

[sv/mxdq_seq.sv]
// Block sequencer: tracks byte position and holds the block scale exponent.
`timescale 1ns / 1ps
`default_nettype none
module mxdq_seq #(
    parameter int PAIRS_PER_BLOCK = mxdq_pkg::PAIRS_PER_BLOCK_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [7:0] data_byte,
    output logic            is_pair,
    output logic [3:0]      pair_index,
    output logic            block_last,
    output logic [7:0]      scale_exp
);
    import mxdq_pkg::*;

    localparam int PW = $clog2(PAIRS_PER_BLOCK + 1);

    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]    scale_reg, scale_next;
    logic [PW-1:0] pair_full;

    assign is_pair    = (pos_reg != '0);
    assign pair_full  = pos_reg - PW'(1);
    assign pair_index = 4'(pair_full);
    assign block_last = (pos_reg == PW'(PAIRS_PER_BLOCK));
    assign scale_exp  = scale_reg;

    always_comb
    begin
        pos_next = pos_reg;
        scale_next = scale_reg;
        if (take)
        begin
            if (!is_pair)
            begin
                pos_next = PW'(1);
                scale_next = (data_byte == SCALE_ZERO_LO || data_byte == SCALE_ZERO_HI)
                             ? 8'd0 : data_byte;
            end
            else
            begin
                pos_next = block_last ? '0 : pos_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            scale_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            scale_reg <= scale_next;
        end
    end
endmodule
`default_nettype wire

[sv/mxdq_check.sv]
// Port-level checker for the dequantizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mxdq_check (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [15:0] value_even,
    input wire logic [3:0]  pair_index,
    input wire logic        block_last
);
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with empty output");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value_even) && $stable(pair_index))
        else $error("stalled result changed");

    a_no_spawn: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !(in_valid && !in_stall) |=> !out_valid)
        else $error("result without transfer");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && block_last && !out_stall ##1 out_valid |-> pair_index == 4'd0)
        else $error("block did not restart at pair zero");
endmodule

bind mxfp4_block_dequant_bf16_unit mxdq_check u_mxdq_check (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .value_even(value_even),
    .pair_index(pair_index), .block_last(block_last)
);
`default_nettype wire

[sim/tb_top.sv]
// Testbench for the MXFP4 dequantizer: directed table, then random blocks vs. a predictor.
`timescale 1ns / 1ps
module tb_top;
    import mxdq_pkg::*;

    localparam int PAIRS = 16;

    typedef struct packed {
        logic [15:0] even;
        logic [15:0] odd;
        logic [3:0]  idx;
        logic        last;
    } pair_t;

    typedef struct {
        logic [7:0] data;
        logic       has_exp;
        pair_t      exp_pair;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] value_even;
    logic [15:0] value_odd;
    logic [3:0]  pair_index;
    logic        block_last;

    mxfp4_block_dequant_bf16_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value_even (value_even),
        .value_odd  (value_odd),
        .pair_index (pair_index),
        .block_last (block_last)
    );

    // predictor state
    int unsigned pos_q;
    logic [15:0] scale_q;
    pair_t       pending_pairs[$];
    int          mismatches;
    bit          quiet_mode;
    bit          hold_off_req;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] scale_elem(logic [3:0] code, logic [15:0] scale);
        logic [7:0] se;
        logic [2:0] m;
        int unsigned eb;
        logic        mb;
        se = scale[14:7];
        m = code[2:0];
        if (m == 3'd0 || se == 8'd0)
            return {code[3], 15'd0};
        if (m == 3'd1)
        begin
            if (se == 8'd1)
                return {code[3], 15'h0040};
            eb = se - 1;
            mb = 1'b0;
        end
        else
        begin
            eb = se + (m >> 1) - 1;
            mb = m[0];
        end
        if (eb >= 255)
            return {code[3], 15'h7F80};
        return {code[3], eb[7:0], mb, 6'd0};
    endfunction

    // advance the predictor by one accepted byte
    function automatic bit dequant_byte(logic [7:0] b, output pair_t p);
        if (pos_q == 0 || pos_q > PAIRS)
        begin
            scale_q = (b == 8'd0 || b == 8'd255) ? 16'd0 : {1'b0, b, 7'd0};
            pos_q = 1;
            return 1'b0;
        end
        p.even = scale_elem(b[3:0], scale_q);
        p.odd = scale_elem(b[7:4], scale_q);
        p.idx = 4'((pos_q - 1) & 15);
        p.last = (pos_q >= PAIRS);
        pos_q = p.last ? 0 : pos_q + 1;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] exp_v, logic [15:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h", what, exp_v, act_v);
    endtask

    // output side: check and stall
    always @(posedge clk)
    begin
        pair_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pairs.size() == 0)
            begin
                report_mismatch("unexpected transfer", 16'd0, value_even);
            end
            else
            begin
                e = pending_pairs.pop_front();
                if (value_even !== e.even)
                    report_mismatch("value_even", e.even, value_even);
                if (value_odd !== e.odd)
                    report_mismatch("value_odd", e.odd, value_odd);
                if (pair_index !== e.idx)
                    report_mismatch("pair_index", 16'(e.idx), 16'(pair_index));
                if (block_last !== e.last)
                    report_mismatch("block_last", 16'(e.last), 16'(block_last));
            end
        end
    end

    int hold_cnt;
    initial
    begin
        out_stall = 1'b0;
        hold_cnt = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req && hold_cnt == 0)
            begin
                hold_cnt = 200;
                hold_off_req = 1'b0;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= (!quiet_mode && $urandom_range(99) < 18);
            end
        end
    end

    // drive one byte and wait for its transfer; valid is left high on return and may drop before the next byte
    task automatic send_byte(logic [7:0] b, bit has_exp, pair_t exp_pair);
        pair_t p;
        bit    r;
        while (!quiet_mode && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        r = dequant_byte(b, p);
        if (r)
        begin
            if (has_exp && p !== exp_pair)
                report_mismatch("table row", exp_pair.even, p.even);
            pending_pairs.push_back(p);
        end
        @(negedge clk);
    endtask

    row_t dir_rows[$];

    task automatic add_row(logic [7:0] b, bit he, pair_t ep);
        row_t r;
        r.data = b;
        r.has_exp = he;
        r.exp_pair = ep;
        dir_rows.push_back(r);
    endtask

    initial
    begin
        pair_t none;
        int    k;
        none = '0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'd0;
        quiet_mode = 1'b0;
        hold_off_req = 1'b0;
        mismatches = 0;
        pos_q = 0;
        scale_q = 16'd0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero scale code: signed zeros, including negative zero
        add_row(8'd0, 1'b0, none);
        add_row(8'h87, 1'b1, '{16'h0000, 16'h8000, 4'd0, 1'b0});
        for (k = 1; k < PAIRS; k++)
            add_row(8'($urandom), 1'b0, none);
        // smallest scale gives the subnormal half
        add_row(8'd1, 1'b0, none);
        add_row(8'h91, 1'b1, '{16'h0040, 16'h8040, 4'd0, 1'b0});
        add_row(8'h7F, 1'b0, none);
        for (k = 2; k < PAIRS; k++)
            add_row(8'($urandom), 1'b0, none);
        // largest nonzero scale: overflow to infinity
        add_row(8'd254, 1'b0, none);
        add_row(8'hF7, 1'b1, '{16'h7F80, 16'hFF80, 4'd0, 1'b0});
        for (k = 2; k < PAIRS; k++)
            add_row(8'($urandom), 1'b0, none);
        add_row(8'h21, 1'b0, none);
        foreach (dir_rows[i])
            send_byte(dir_rows[i].data, dir_rows[i].has_exp, dir_rows[i].exp_pair);

        // random: whole blocks of random bytes, one quiet stretch and one long output stall
        for (int blk = 0; blk < 35; blk++)
        begin
            quiet_mode = (blk >= 10 && blk < 16);
            if (blk == 20)
                hold_off_req = 1'b1;
            for (k = 0; k <= PAIRS; k++)
                send_byte(8'($urandom_range(255)), 1'b0, none);
        end
        in_valid <= 1'b0;
        quiet_mode = 1'b0;
        while (pending_pairs.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
